// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the box mean filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define BMF_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define BMF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bmf_pkg.sv =====
// Package with the constants, register indexes and reciprocal table of the box mean filter.
package bmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_KERNEL_DEF = 15;

   localparam logic [10:0] HEIGHT_LIMIT = 11'd1024;

   localparam int PIX_W   = 8;
   localparam int SUM_W   = 16;
   localparam int COL_W   = 12;
   localparam int TOT_W   = 13;
   localparam int RECIP_W = 25;
   localparam int FRAC_W  = 24;

   typedef enum logic [1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_NONE   = 2'd3
   } csr_index_type;

   // Rounded-up 2^24 / (k*k) for every odd kernel size; the error term stays
   // below k*k, which keeps the quotient exact for any 16-bit sum.
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
      logic [RECIP_W-1:0] m;
      unique case (k)
         4'd3:    m = 25'd1864136;
         4'd5:    m = 25'd671089;
         4'd7:    m = 25'd342393;
         4'd9:    m = 25'd207127;
         4'd11:   m = 25'd138655;
         4'd13:   m = 25'd99274;
         4'd15:   m = 25'd74566;
         default: m = 25'd16777216;
      endcase
      return m;
   endfunction

endpackage

// ===== src/box_mean_filter.sv =====
// Box mean filter top level: counters, line store, column sums and the emit sequencer.
// An item passes through accept, the calc state and a step, with an emit state for each result,
// plus h steps (half the kernel) at the last column of an output row; one item is handled at a
// time and a held result stalls it. A result is registered in the divider, then at the output;
// memories are read at accept and written in calc. Synchronous active-high reset clears the
// counters, window sum and output, restores kernel 3 and 512 x 512; memories need no clearing.
module box_mean_filter #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = bmf_pkg::MAX_KERNEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic        req_tuser,   // [0] is_drain
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] mean_value
   output logic        rsp_tlast,   // end_of_frame
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import bmf_pkg::*;

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int STORE_DEPTH = (MAX_KERNEL - 1) * MAX_WIDTH;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int KCAP        = (MAX_KERNEL > 15) ? 15 : MAX_KERNEL;
   localparam int KTOP        = ((KCAP % 2) == 0) ? KCAP - 1 : KCAP;
   localparam int SH_DEPTH    = KTOP;
   localparam int SIW         = $clog2(SH_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_STEP, S_EMIT} state_type;

   state_type state_ff, state_in;
   logic [3:0]        kset_ff, kset_in;
   logic [10:0]       width_ff, width_in;
   logic [10:0]       height_ff, height_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [10:0]       row_ff, row_in;
   logic [3:0]        lr_ff, lr_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [PIX_W-1:0]  p_ff, p_in;
   logic [SUM_W-1:0]  ws_ff, ws_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   logic [2:0]        t_ff, t_in;
   logic              more_ff, more_in;
   logic              eof_ff, eof_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [TOT_W-1:0]  sh_ff [SH_DEPTH];

   logic [PIX_W-1:0]  line_mem [STORE_DEPTH];
   logic [COL_W-1:0]  col_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  line_q_ff;
   logic [COL_W-1:0]  col_q_ff;

   logic [3:0]        k_eff;
   logic [2:0]        h_eff;
   logic [CW-1:0]     wlast;
   logic [10:0]       ht_eff;
   logic [10:0]       rows_last;
   logic              emitting, last_row;
   logic              accept, calc, mem_wr, div_load;
   logic [TOT_W-1:0]  partial, total, leave;
   logic [PIX_W-1:0]  old;
   logic [COL_W-1:0]  colsum_wr;
   logic [CW:0]       col_t;
   logic [3:0]        back_idx;
   logic [PIX_W-1:0]  quot;

   // Kernel normalisation: zero becomes one, even values drop by one, and the result is capped at KTOP.
   always_comb begin
      logic [3:0] kn;
      kn = (kset_ff == 4'd0) ? 4'd1 : kset_ff;
      if (!kn[0]) begin
         kn = kn - 4'd1;
      end
      if (int'(kn) > KTOP) begin
         kn = 4'(KTOP);
      end
      k_eff = kn;
   end
   assign h_eff = k_eff[3:1];

   always_comb begin
      if (width_ff == 11'd0) begin
         wlast = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(width_ff - 11'd1);
      end
      if (height_ff == 11'd0) begin
         ht_eff = 11'd1;
      end else if (height_ff > HEIGHT_LIMIT) begin
         ht_eff = HEIGHT_LIMIT;
      end else begin
         ht_eff = height_ff;
      end
   end

   assign rows_last = ht_eff + {8'd0, h_eff} - 11'd1;
   assign emitting  = (row_ff >= {8'd0, h_eff});
   assign last_row  = (row_ff == rows_last);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign calc       = (state_ff == S_CALC);
   assign mem_wr     = calc && (k_eff > 4'd1);

   // Column total for the current item from the registered memory reads.
   assign partial = (row_ff == 11'd0) ? '0 : {1'b0, col_q_ff};
   assign total   = partial + {5'd0, p_ff};
   assign old     = (row_ff >= {7'd0, k_eff - 4'd1}) ? line_q_ff : '0;
   assign colsum_wr = (k_eff > 4'd1) ? COL_W'(total - {5'd0, old}) : '0;
   assign leave   = ({1'b0, col_ff} >= (CW+1)'(k_eff)) ? sh_ff[SIW'(k_eff - 4'd1)] : '0;
   assign col_t   = {1'b0, col_ff} + (CW+1)'(t_ff);
   assign back_idx = k_eff - {1'b0, t_ff};

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[addr_ff] <= p_ff;
      end
      if (accept) begin
         line_q_ff <= line_mem[base_ff + AW'(col_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (calc) begin
         col_mem[col_ff] <= colsum_wr;
      end
      if (accept) begin
         col_q_ff <= col_mem[col_ff];
      end
   end

   // Shift line of the latest column totals of the current row.
   always_ff @(posedge clock) begin
      if (calc) begin
         sh_ff[0] <= total;
         for (int j = 1; j < SH_DEPTH; j++) begin
            sh_ff[j] <= sh_ff[j-1];
         end
      end
   end

   bmf_mean_div u_div (
      .clock    (clock),
      .load     (div_load),
      .sum      (s_in),
      .kernel   (k_eff),
      .quotient (quot)
   );

   always_comb begin
      logic emit_now;
      logic eof_now;
      logic finish;
      state_in     = state_ff;
      kset_in      = kset_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lr_in        = lr_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      p_in         = p_ff;
      ws_in        = ws_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      more_in      = more_ff;
      eof_in       = eof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      div_load     = 1'b0;
      emit_now     = 1'b0;
      eof_now      = 1'b0;
      finish       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               addr_in  = base_ff + AW'(col_ff);
               p_in     = ((row_ff < ht_eff) && !req_tuser) ? req_tdata : '0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (col_ff == '0) begin
               ws_in = {3'd0, total};
            end else begin
               ws_in = ws_ff + {3'd0, total} - {3'd0, leave};
            end
            s_in     = ws_in;
            t_in     = 3'd0;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (t_ff == 3'd0) begin
               emit_now = emitting && ({1'b0, col_ff} >= (CW+1)'(h_eff));
               eof_now  = (h_eff == 3'd0) && last_row && (col_ff == wlast);
               more_in  = emitting && (col_ff == wlast) && (h_eff != 3'd0);
            end else begin
               if (col_t >= (CW+1)'(k_eff)) begin
                  s_in = s_ff - {3'd0, sh_ff[SIW'(back_idx)]};
               end
               emit_now = (col_t >= (CW+1)'(h_eff));
               eof_now  = last_row && (t_ff == h_eff);
               more_in  = (t_ff < h_eff);
            end
            if (emit_now) begin
               div_load = 1'b1;
               eof_in   = eof_now;
               state_in = S_EMIT;
            end else if (more_in) begin
               t_in = t_ff + 3'd1;
            end else begin
               finish = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quot;
               rsp_last_in  = eof_ff;
               if (more_ff) begin
                  t_in     = t_ff + 3'd1;
                  state_in = S_STEP;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         state_in = S_IDLE;
         if (col_ff == wlast) begin
            col_in = '0;
            if (row_ff == rows_last) begin
               row_in  = '0;
               lr_in   = '0;
               base_in = '0;
            end else begin
               row_in = row_ff + 11'd1;
               if (k_eff > 4'd1) begin
                  if (lr_ff == k_eff - 4'd2) begin
                     lr_in   = '0;
                     base_in = '0;
                  end else begin
                     lr_in   = lr_ff + 4'd1;
                     base_in = base_ff + AW'(MAX_WIDTH);
                  end
               end
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      // Any register write restarts the frame.
      if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL: kset_in   = csr_wdata[3:0];
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    ;
         endcase
         col_in  = '0;
         row_in  = '0;
         lr_in   = '0;
         base_in = '0;
         ws_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kset_ff      <= 4'd3;
         width_ff     <= 11'd512;
         height_ff    <= 11'd512;
         col_ff       <= '0;
         row_ff       <= '0;
         lr_ff        <= '0;
         base_ff      <= '0;
         ws_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kset_ff      <= kset_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lr_ff        <= lr_in;
         base_ff      <= base_in;
         ws_ff        <= ws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      p_ff        <= p_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      more_ff     <= more_in;
      eof_ff      <= eof_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "assert_macros.svh"

   `BMF_ASSERT(col_in_range, clock, reset, col_ff <= wlast, "column counter beyond row end")
   `BMF_ASSERT(row_in_range, clock, reset, row_ff <= rows_last, "row counter beyond drain rows")
   `BMF_ASSERT_IMP(line_row_in_range, clock, reset, k_eff > 4'd1, lr_ff < k_eff - 4'd1, "line row out of range")

endmodule

// ===== src/bmf_mean_div.sv =====
// Registered division of the window sum by the kernel area through a reciprocal product.
module bmf_mean_div (
   input  logic                       clock,
   input  logic                       load,
   input  logic [bmf_pkg::SUM_W-1:0]  sum,
   input  logic [3:0]                 kernel,
   output logic [bmf_pkg::PIX_W-1:0]  quotient
);
   import bmf_pkg::*;

   logic [SUM_W+RECIP_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= sum * recip(kernel);
      end
   end

   assign quotient = prod_ff[FRAC_W +: PIX_W];

endmodule

// ===== tb/box_mean_filter_checker.sv =====
// Checker for the box mean filter: predicts every result from the accepted items and compares.
`timescale 1ns / 1ps
module box_mean_filter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import bmf_pkg::*;

   localparam int STORE_DEPTH = (MAX_KERNEL_DEF - 1) * MAX_WIDTH_DEF;

   typedef struct packed {
      logic [7:0] mean;
      logic       eof;
   } pixel_out_type;

   pixel_out_type expected_q[$];
   logic [3:0]  kernel_reg;
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   logic [7:0]  line_mem [0:STORE_DEPTH-1];
   logic [11:0] col_sum [0:MAX_WIDTH_DEF-1];
   logic [15:0] col_ring [0:31];
   logic [15:0] win_sum;
   int          row_pos;
   int          col_pos;

   assign pending = expected_q.size();

   function automatic int kernel_eff(input logic [3:0] kset);
      int k;
      k = kset;
      if (k == 0) k = 1;
      if (k % 2 == 0) k = k - 1;
      if (k > MAX_KERNEL_DEF) k = MAX_KERNEL_DEF;
      return k;
   endfunction

   function automatic int size_eff(input logic [10:0] v, input int lim);
      int s;
      s = v;
      if (s < 1) s = 1;
      if (s > lim) s = lim;
      return s;
   endfunction

   // Works out the results caused by one accepted pixel and advances the position.
   task automatic predict_pixel(input logic [7:0] pix, input logic drain);
      int k, hk, area, w, ht, rows, r, c, p, total, old, leave, s, oc, gone, idx;
      logic emitting, last_row;
      pixel_out_type o;
      k = kernel_eff(kernel_reg);
      hk = k / 2;
      area = k * k;
      w = size_eff(width_reg, MAX_WIDTH_DEF);
      ht = size_eff(height_reg, 1024);
      rows = ht + hk;
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      if (r >= rows) r = 0;
      p = (r < ht && !drain) ? int'(pix) : 0;
      total = ((r == 0) ? 0 : int'(col_sum[c])) + p;
      if (k > 1) begin
         idx = (r % (k - 1)) * MAX_WIDTH_DEF + c;
         old = 0;
         if (idx < STORE_DEPTH) begin
            if (r >= k - 1) old = line_mem[idx];
            line_mem[idx] = p[7:0];
         end
         col_sum[c] = 12'((total - old) & 'hFFF);
      end else begin
         col_sum[c] = '0;
      end
      col_ring[c & 31] = 16'(total);
      leave = (c >= k) ? int'(col_ring[(c - k) & 31]) : 0;
      if (c == 0) win_sum = 16'(total);
      else win_sum = 16'((int'(win_sum) + total - leave) & 'hFFFF);
      emitting = (r >= hk) && (r - hk < ht);
      last_row = (r == rows - 1);
      if (emitting && c >= hk) begin
         o.mean = 8'(int'(win_sum) / area);
         o.eof = last_row && (c - hk == w - 1);
         expected_q.push_back(o);
      end
      if (emitting && c == w - 1) begin
         s = win_sum;
         for (int t = 1; t <= hk; t++) begin
            oc = c - hk + t;
            gone = oc - hk - 1;
            if (gone >= 0) s = (s - int'(col_ring[gone & 31])) & 'hFFFF;
            if (oc >= 0) begin
               o.mean = 8'(s / area);
               o.eof = last_row && (oc == w - 1);
               expected_q.push_back(o);
            end
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   always @(posedge clock) begin
      pixel_out_type e;
      if (reset) begin
         kernel_reg <= 4'd3;
         width_reg <= 11'd512;
         height_reg <= 11'd512;
         for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = '0;
         for (int i = 0; i < MAX_WIDTH_DEF; i++) col_sum[i] = '0;
         for (int i = 0; i < 32; i++) col_ring[i] = '0;
         win_sum = '0;
         row_pos = 0;
         col_pos = 0;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_KERNEL: kernel_reg <= csr_wdata[3:0];
               CSR_WIDTH:  width_reg <= csr_wdata;
               CSR_HEIGHT: height_reg <= csr_wdata;
               default: ;
            endcase
            row_pos = 0;
            col_pos = 0;
            win_sum = '0;
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result mean=%0d eof=%0b", $time, rsp_tdata, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.mean !== rsp_tdata || e.eof !== rsp_tlast) begin
                  $display("%0t: mismatch, expected mean=%0d eof=%0b, actual mean=%0d eof=%0b",
                           $time, e.mean, e.eof, rsp_tdata, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the box mean filter: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb;
   import bmf_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_NONE;
   logic [10:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   int          stall_left = 0;
   int          pixels_sent = 0;
   logic        calm = 1'b0;
   logic        quiet = 1'b0;

   box_mean_filter DUT (.*);

   box_mean_filter_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result-side back-pressure in random bursts, none while quiet or calm.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [10:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [3:0] kset, input logic [10:0] w, input logic [10:0] h);
      if ($urandom_range(0, 3) == 0) csr_write(CSR_NONE, 11'($urandom));
      csr_write(CSR_HEIGHT, h);
      csr_write(CSR_KERNEL, 11'(kset));
      csr_write(CSR_WIDTH, w);
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] pix, input logic drain);
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= drain;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // Waits until the block is idle and every expected result has arrived.
   task automatic settle;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0 || !req_tready);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_frame(input logic [3:0] kset, input logic [10:0] w, input logic [10:0] h,
                            input int count);
      set_frame(kset, w, h);
      for (int i = 0; i < count; i++)
         send_pixel(8'($urandom), $urandom_range(0, 9) == 0);
      settle();
   endtask

   initial begin
      int kset, wv, hv, kk, we, he, count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest kernel and frame, full-scale pixels, drain inside the image.
      set_frame(4'd0, 11'd1, 11'd1);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'hA5, 1'b0);
      settle();
      // Even kernel setting, white frame with white pixels offered in the drain row.
      set_frame(4'd4, 11'd3, 11'd2);
      for (int i = 0; i < 6; i++) send_pixel(8'hFF, 1'b0);
      for (int i = 0; i < 3; i++) send_pixel(8'hFF, 1'b0);
      settle();
      // Width and height of zero and of the field's top value saturate; then the limit size with kernel setting 14.
      run_frame(4'd15, 11'd0, 11'd0, 10);
      run_frame(4'd15, 11'd2047, 11'd2047, 6);
      run_frame(4'd14, 11'd1024, 11'd1024, 3);

      while (pixels_sent < 450) begin
         quiet = (pixels_sent > 380);
         calm = ($urandom_range(0, 3) == 0);
         kset = $urandom_range(0, 15);
         wv = $urandom_range(1, 12);
         hv = $urandom_range(1, 6);
         case ($urandom_range(0, 9))
            0: wv = 1024;
            1: wv = 0;
            2: hv = $urandom_range(0, 1) ? 2047 : 0;
            default: ;
         endcase
         kk = kset == 0 ? 1 : (kset % 2 == 0 ? kset - 1 : kset);
         we = wv < 1 ? 1 : (wv > 1024 ? 1024 : wv);
         he = hv < 1 ? 1 : (hv > 1024 ? 1024 : hv);
         count = we * (he + kk / 2);
         if (count > 120) count = $urandom_range(20, 60);
         else if ($urandom_range(0, 2) == 0) count = count * 2 + $urandom_range(0, we);
         run_frame(4'(kset), 11'(wv), 11'(hv), count);
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
